FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the queue geometry, the entry layout, the operation and status codes
// and the control word that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int FILL_W   = 4;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // Request operation codes as they arrive in tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_PULL   = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_e;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_RSVD   = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [VALUE_W-1:0]       value;
  } entry_t;

  // Control word broadcast to the whole chain.
  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

FILE: src/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue on a chain of cells
// Eight entries kept sorted by descending signed priority; insert, pull,
// peek and no-op requests each produce one result.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser carries the operation code
//   (insert, pull, peek, or a no-op), tdata the priority and payload of an
//   insert. Each request yields exactly one result on m_axis: the head
//   payload for a successful pull or peek (zero otherwise), a status code in
//   tuser, and the fill count with empty and full flags after the request.
//   The result is registered at the edge that accepts the request and is
//   offered in the following cycle. One request per cycle
//   is accepted while results are taken, because every cell compares its own
//   priority against the new one in parallel and the whole chain shifts in
//   that same edge; the single compare per cell sets the cycle time.
//   When the receiver stalls, the held result keeps s_axis_tready low, so no
//   request is lost or overtaken; the next request is taken in the cycle the
//   held result leaves. Equal priorities leave in arrival order. An insert
//   into a full queue is dropped with the full status; pull or peek on an
//   empty queue reports the empty status. Reset empties the queue and the
//   result register at once; entry contents are not cleared.
module sorted_priority_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tuser: [1:0] func
  input  logic [1:0]  s_axis_tuser,
  // tdata: [15:0] priority_req, [47:16] item_value
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: [1:0] status
  output logic [1:0]  m_axis_tuser,
  // tdata: [31:0] head_value, [35:32] fill_count, [36] is_empty, [37] is_full,
  // [39:38] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);
  import spq_pkg::*;

  // Request fields.
  func_e                    req_func;
  logic signed [PRIO_W-1:0] req_prio;
  logic [VALUE_W-1:0]       req_value;
  logic                     req_fire;

  assign req_func  = func_e'(s_axis_tuser[FUNC_W-1:0]);
  assign req_prio  = s_axis_tdata[PRIO_W-1:0];
  assign req_value = s_axis_tdata[PRIO_W +: VALUE_W];

  // The result register frees itself in the cycle its content is taken.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  // Fill count of the chain.
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             q_empty;
  logic             q_full;

  assign q_empty = (count_q == '0);
  assign q_full  = (count_q == CNT_W'(CAPACITY));

  // Chain of cells.
  cell_ctrl_t          ctrl;
  entry_t              cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_keep;
  logic [CAPACITY-1:0] cell_occ;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t left_entry;
      entry_t right_entry;
      logic   left_keep;

      assign cell_occ[gi] = (CNT_W'(gi) < count_q);

      if (gi == 0) begin : g_first
        // The head has nothing in front of it, so it takes the new entry
        // whenever its own entry loses the compare.
        assign left_keep  = 1'b1;
        assign left_entry = ctrl.new_entry;
      end else begin : g_inner
        assign left_keep  = cell_keep[gi-1];
        assign left_entry = cell_entry[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        // The tail slot becomes free on a pull; its content is stale anyway.
        assign right_entry = cell_entry[gi];
      end else begin : g_body
        assign right_entry = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occupied_i    (cell_occ[gi]),
        .left_keep_i   (left_keep),
        .left_entry_i  (left_entry),
        .right_entry_i (right_entry),
        .entry_o       (cell_entry[gi]),
        .keep_o        (cell_keep[gi])
      );
    end
  endgenerate

  // Decode the request into a chain command and the result it produces.
  status_e            res_status;
  logic [VALUE_W-1:0] res_head;

  always_comb begin
    ctrl.op                  = CELL_HOLD;
    ctrl.new_entry.prio      = req_prio;
    ctrl.new_entry.value     = req_value;
    count_d                  = count_q;
    res_status               = STATUS_OK;
    res_head                 = '0;
    case (req_func)
      FUNC_INSERT: begin
        if (q_full) begin
          res_status = STATUS_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      FUNC_PULL: begin
        if (q_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          ctrl.op  = CELL_SHIFT;
          count_d  = count_q - CNT_W'(1);
          res_head = cell_entry[0].value;
        end
      end
      FUNC_PEEK: begin
        if (q_empty) begin
          res_status = STATUS_EMPTY;
        end else begin
          res_head = cell_entry[0].value;
        end
      end
      default: begin
        ctrl.op = CELL_HOLD;
      end
    endcase
    // Nothing moves unless a request is actually taken.
    if (!req_fire) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  // Result register.
  logic                out_valid_q;
  logic [VALUE_W-1:0]  out_head_q;
  status_e             out_status_q;
  logic [CNT_W-1:0]    out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_head_q   <= res_head;
      out_status_q <= res_status;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00,
                          (out_count_q == CNT_W'(CAPACITY)),
                          (out_count_q == '0),
                          FILL_W'(out_count_q),
                          out_head_q};

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // A pull on a non-empty queue removes exactly one entry.
  a_pull_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_func == FUNC_PULL && !q_empty)
      |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pull did not remove one entry");

  // An insert into a full queue leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_func == FUNC_INSERT && q_full) |=> q_full)
    else $error("insert into full queue changed the fill count");

  // Occupied neighbors stay in descending priority order.
  generate
    for (gi = 0; gi < CAPACITY - 1; gi++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
        cell_occ[gi+1] |-> (cell_entry[gi].prio >= cell_entry[gi+1].prio))
        else $error("chain lost its priority order");
    end
  endgenerate

endmodule

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On an insert it keeps its entry, takes the new one or takes
// its left neighbor's entry; on a pull it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_keep_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  spq_pkg::entry_t     right_entry_i,
  output spq_pkg::entry_t     entry_o,
  output logic                keep_o
);
  import spq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // An occupied cell whose priority is at least the new one stays in front.
  assign keep_o = occupied_i && (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (!keep_o) begin
          entry_d = left_keep_i ? ctrl_i.new_entry : left_entry_i;
        end
      end
      CELL_SHIFT: begin
        entry_d = right_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: test/sorted_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker: result predictor and scoreboard
// Watches both stream channels of the sorted priority queue, keeps its own
// copy of the queue contents, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  s_tuser_i,
  input  logic [47:0] s_tdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [1:0]  m_tuser_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  output int          error_count_o,
  output int          pending_o,
  output int          checked_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] head_value;
    status_e            status;
    logic [FILL_W-1:0]  fill_count;
    logic               is_empty;
    logic               is_full;
  } queue_result_t;

  // Shadow copy of the queue, sorted by descending priority.
  logic signed [PRIO_W-1:0] shadow_prio [CAPACITY];
  logic [VALUE_W-1:0]       shadow_value [CAPACITY];
  int unsigned              shadow_count;

  queue_result_t awaited_results [$];

  // Applies one request to the shadow queue and returns the result it causes.
  function automatic queue_result_t apply_request(func_e op,
                                                  logic signed [PRIO_W-1:0] prio,
                                                  logic [VALUE_W-1:0] value);
    queue_result_t res;
    int            pos;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      FUNC_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // Move past every entry of strictly lower priority only, so ties
          // stay in arrival order.
          pos = shadow_count;
          while (pos > 0 && shadow_prio[pos-1] < prio) begin
            shadow_prio[pos]  = shadow_prio[pos-1];
            shadow_value[pos] = shadow_value[pos-1];
            pos--;
          end
          shadow_prio[pos]  = prio;
          shadow_value[pos] = value;
          shadow_count++;
        end
      end
      FUNC_PULL, FUNC_PEEK: begin
        if (shadow_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.head_value = shadow_value[0];
          if (op == FUNC_PULL) begin
            for (int i = 0; i + 1 < shadow_count; i++) begin
              shadow_prio[i]  = shadow_prio[i+1];
              shadow_value[i] = shadow_value[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.fill_count = FILL_W'(shadow_count);
    res.is_empty   = (shadow_count == 0);
    res.is_full    = (shadow_count == CAPACITY);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      awaited_results.delete();
      error_count_o = 0;
      checked_o = 0;
    end else begin
      // Results are taken first so that a result with nothing awaited is caught
      // even when a request is accepted at the same edge.
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: tuser %0h tdata %0h", m_tuser_i, m_tdata_i);
          error_count_o++;
        end else begin
          want = awaited_results.pop_front();
          checked_o++;
          if (m_tdata_i[31:0] !== want.head_value) begin
            $error("head_value: expected %0h, got %0h", want.head_value, m_tdata_i[31:0]);
            error_count_o++;
          end
          if (m_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser_i);
            error_count_o++;
          end
          if (m_tdata_i[35:32] !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, m_tdata_i[35:32]);
            error_count_o++;
          end
          if (m_tdata_i[36] !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, m_tdata_i[36]);
            error_count_o++;
          end
          if (m_tdata_i[37] !== want.is_full) begin
            $error("is_full: expected %0b, got %0b", want.is_full, m_tdata_i[37]);
            error_count_o++;
          end
          if (m_tdata_i[39:38] !== 2'b00) begin
            $error("tdata pad: expected 0, got %0b", m_tdata_i[39:38]);
            error_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited_results.push_back(apply_request(func_e'(s_tuser_i),
                                                s_tdata_i[15:0], s_tdata_i[47:16]));
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

FILE: test/tb_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit: testbench for the sorted priority queue
// Drives insert, pull, peek and no-op requests with random gaps and result
// stalls, and lets a separate checker predict and compare every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int RANDOM_REQUESTS = 1340;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic [1:0]  s_axis_tuser;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [1:0]  m_axis_tuser;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  int error_count;
  int pending_count;
  int checked_count;
  int idle_cycles;
  int n_insert, n_pull, n_peek, n_nop;
  bit gaps_off;

  sorted_priority_queue_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  sorted_priority_queue_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tuser_i     (s_axis_tuser),
    .s_tdata_i     (s_axis_tdata),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .m_tuser_i     (m_axis_tuser),
    .m_tdata_i     (m_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .error_count_o (error_count),
    .pending_o     (pending_count),
    .checked_o     (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length in cycles: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (gaps_off) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one request at a falling edge, after an optional gap during
  // which tvalid is low and the data lines carry noise. Returns at the falling
  // edge after the request was accepted.
  task automatic send_request(input func_e op, input logic [PRIO_W-1:0] prio,
                              input logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= 2'($urandom);
      s_axis_tdata  <= {$urandom, 16'($urandom)};
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {value, prio};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    case (op)
      FUNC_INSERT: n_insert++;
      FUNC_PULL:   n_pull++;
      FUNC_PEEK:   n_peek++;
      default:     n_nop++;
    endcase
  endtask

  // Result side: the receiver takes results for a while, then may stall.
  initial begin
    int run;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      run = $urandom_range(1, 20);
      m_axis_tready <= 1'b1;
      repeat (run) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results awaited",
               WATCHDOG_LIMIT, pending_count);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 insert_pct;
    int                 roll;
    int                 counted;
    int                 tmp;
    func_e              op;
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = '0;
    s_axis_tdata  = '0;
    idle_cycles   = 0;
    gaps_off      = 1'b0;
    n_insert = 0;
    n_pull   = 0;
    n_peek   = 0;
    n_nop    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty queue reports, the no-op, the priority extremes,
    // ties that must leave in arrival order, an insert into a full queue,
    // and a complete drain back to empty.
    send_request(FUNC_PEEK, 16'h1234, 32'hDEAD_BEEF);
    send_request(FUNC_PULL, 16'h8000, 32'hFFFF_FFFF);
    send_request(FUNC_NOP, 16'h7FFF, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 16'h0005, 32'h0000_00A1);
    send_request(FUNC_INSERT, 16'h8000, 32'h0000_0000);
    send_request(FUNC_INSERT, 16'h0005, 32'h0000_00A2);
    send_request(FUNC_INSERT, 16'h7FFF, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 16'hFFFF, 32'h5555_5555);
    send_request(FUNC_INSERT, 16'h0005, 32'h0000_00A3);
    send_request(FUNC_INSERT, 16'h0000, 32'hAAAA_AAAA);
    send_request(FUNC_INSERT, 16'h8000, 32'h8000_0001);
    send_request(FUNC_INSERT, 16'h7FFF, 32'h1234_5678);
    send_request(FUNC_NOP, 16'h0000, 32'h0000_0000);
    send_request(FUNC_PEEK, 16'hFFFF, 32'h0000_0000);
    repeat (8) send_request(FUNC_PULL, 16'($urandom), $urandom);
    send_request(FUNC_PULL, 16'h0000, 32'h0000_0000);

    // Random part: blocks of requests that lean toward filling, draining or
    // holding the queue, so it spends time both full and empty. Tied
    // priorities are common to exercise arrival ordering.
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      gaps_off = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       insert_pct = 75;
        1:       insert_pct = 25;
        default: insert_pct = 50;
      endcase
      repeat ($urandom_range(40, 120)) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          op = FUNC_NOP;
        end else if ($urandom_range(0, 99) < insert_pct) begin
          op = FUNC_INSERT;
        end else begin
          op = ($urandom_range(0, 9) < 7) ? FUNC_PULL : FUNC_PEEK;
        end
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
          tmp  = $urandom_range(0, 4);
          prio = 16'(tmp - 2);
        end else if (roll == 4) begin
          case ($urandom_range(0, 3))
            0:       prio = 16'h7FFF;
            1:       prio = 16'h8000;
            2:       prio = 16'h0000;
            default: prio = 16'hFFFF;
          endcase
        end else begin
          prio = 16'($urandom);
        end
        case ($urandom_range(0, 15))
          0:       value = 32'h0000_0000;
          1:       value = 32'hFFFF_FFFF;
          default: value = $urandom;
        endcase
        send_request(op, prio, value);
        counted++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);

    $display("Requests sent: %0d inserts, %0d pulls, %0d peeks, %0d no-ops",
             n_insert, n_pull, n_peek, n_nop);
    $display("Results compared: %0d, mismatches: %0d", checked_count, error_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
